// ===== rtl/core/shv_pkg.sv =====
// Shared types and constants for the ServerHello validator.
// No dependencies; used by the top level and the testbench.
package shv_pkg;

  localparam int unsigned KEY_BYTES_DEF = 32;

  localparam logic [7:0]  HS_TYPE_SERVER_HELLO = 8'h02;
  localparam logic [7:0]  LEGACY_VER_BYTE      = 8'h03;
  localparam logic [7:0]  SUITE_HI             = 8'h13;
  localparam logic [7:0]  SUITE_LO             = 8'h01;
  localparam logic [7:0]  GROUP_X25519_LO      = 8'h1D;
  localparam logic [7:0]  SUP_VER_HI           = 8'h03;
  localparam logic [7:0]  SUP_VER_LO           = 8'h04;
  localparam logic [15:0] EXT_KEY_SHARE        = 16'd51;
  localparam logic [15:0] EXT_SUP_VER          = 16'd43;
  localparam logic [15:0] SUP_VER_BODY_LEN     = 16'd2;
  localparam logic [23:0] MIN_BODY_LEN         = 24'd40;
  localparam logic [23:0] COUNT_MAX            = 24'hFFFFFF;

  typedef enum logic [3:0] {
    ST_OK      = 4'd0,
    ST_TYPE    = 4'd1,
    ST_LEN     = 4'd2,
    ST_VER     = 4'd3,
    ST_RETRY   = 4'd4,
    ST_SUITE   = 4'd5,
    ST_COMP    = 4'd6,
    ST_EXTLEN  = 4'd7,
    ST_SHARE   = 4'd8,
    ST_SUPVER  = 4'd9,
    ST_MISSING = 4'd10
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [3:0] status;
    logic [7:0] key_byte;
    logic       run_end;
  } out_word_t;

  // Fixed random that marks a HelloRetryRequest.
  function automatic logic [7:0] retry_random(input logic [4:0] idx);
    logic [7:0] r;
    case (idx)
      5'd0:  r = 8'hCF;  5'd1:  r = 8'h21;  5'd2:  r = 8'hAD;  5'd3:  r = 8'h74;
      5'd4:  r = 8'hC3;  5'd5:  r = 8'hFD;  5'd6:  r = 8'h77;  5'd7:  r = 8'h49;
      5'd8:  r = 8'h20;  5'd9:  r = 8'h6D;  5'd10: r = 8'h5D;  5'd11: r = 8'h60;
      5'd12: r = 8'h1D;  5'd13: r = 8'hF2;  5'd14: r = 8'hEE;  5'd15: r = 8'hF7;
      5'd16: r = 8'h07;  5'd17: r = 8'hD0;  5'd18: r = 8'h42;  5'd19: r = 8'hA9;
      5'd20: r = 8'h37;  5'd21: r = 8'h8E;  5'd22: r = 8'hCD;  5'd23: r = 8'h1F;
      5'd24: r = 8'h38;  5'd25: r = 8'h29;  5'd26: r = 8'hB3;  5'd27: r = 8'h73;
      5'd28: r = 8'h0B;  5'd29: r = 8'h37;  5'd30: r = 8'h8E;  5'd31: r = 8'h3E;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/shv_stream_if.sv =====
// Valid/ready stream channel carrying one word per handshake.
// Payload type is a parameter; used with shv_pkg word types.
interface shv_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/server_hello_validator.sv =====
// TLS 1.3 ServerHello validator top level.
// Depends on shv_pkg and shv_stream_if.
//
// Usage:
//   in_i  : one message byte per word, last_byte set on the final byte.
//   out_o : per message, one word with the error status and run_end set, or
//           on success KEY_BYTES words with status 0 carrying the x25519 key
//           in order, run_end on the last one.
// Each accepted byte lands in an input register and is parsed in the next
// cycle, so a byte per cycle is sustained unless a final byte is waiting. A
// final byte's result is loaded from the input register into the output buffer.
// A result run is held in an output buffer with its own key copy; bytes of
// the next message keep flowing while it drains. A final byte waits in the
// input register (ready low) until the buffer has room: the draining of a run
// of up to KEY_BYTES words at full out_o.ready sets the pace for back-to-back
// short messages.
// A stalled out_o holds the current word; in_i stalls only when a final byte
// is waiting behind a full buffer.
// Reset clears the parser to the header phase and empties both registers;
// the key store itself is not cleared.
module server_hello_validator #(
  parameter int unsigned KEY_BYTES = shv_pkg::KEY_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  shv_stream_if.sink   in_i,
  shv_stream_if.source out_o
);
  import shv_pkg::*;

  localparam int unsigned KW = $clog2(KEY_BYTES);
  localparam logic [KW-1:0] KIDX_LAST = KW'(KEY_BYTES - 1);
  localparam logic [15:0] SHARE_BODY_LEN = 16'(KEY_BYTES + 4);
  localparam logic [7:0]  KEY_LEN_BYTE = 8'(KEY_BYTES);

  typedef enum logic [10:0] {
    PH_HEAD    = 11'b000_0000_0001,
    PH_VER     = 11'b000_0000_0010,
    PH_RAND    = 11'b000_0000_0100,
    PH_SIDLEN  = 11'b000_0000_1000,
    PH_SID     = 11'b000_0001_0000,
    PH_SUITE   = 11'b000_0010_0000,
    PH_COMP    = 11'b000_0100_0000,
    PH_EXTLEN  = 11'b000_1000_0000,
    PH_EXTHDR  = 11'b001_0000_0000,
    PH_EXTBODY = 11'b010_0000_0000,
    PH_TAIL    = 11'b100_0000_0000
  } phase_e;

  // input register
  logic     in_vld_q;
  in_word_t in_word_q;

  // parse state
  phase_e      phase_q, phase_d;
  logic [23:0] cnt_q, cnt_d;
  logic [23:0] decl_q, decl_d;
  logic [7:0]  sid_q, sid_d;
  logic [15:0] ebl_q, ebl_d;
  logic [15:0] etype_q, etype_d;
  logic [15:0] ebody_q, ebody_d;
  logic [5:0]  ebi_q, ebi_d;
  logic        rmatch_q, rmatch_d;
  logic [1:0]  seen_q, seen_d;
  status_e     err_q, err_d;

  logic [7:0]  key_q [KEY_BYTES];
  logic          key_we;
  logic [KW-1:0] key_wa;

  // result buffer
  logic          res_vld_q;
  status_e       res_status_q;
  logic [7:0]    res_key_q [KEY_BYTES];
  logic [KW-1:0] res_idx_q;

  logic        proc, buf_free, out_fire, res_last, fin_load;
  logic [7:0]  b;
  logic [6:0]  ebi_inc;
  logic [23:0] used, room;
  logic [24:0] decl_plus4;
  logic [6:0]  kofs;
  status_e     fin_status;

  assign b        = in_word_q.data_byte;
  assign ebi_inc  = {1'b0, ebi_q} + 7'd1;
  assign kofs     = {1'b0, ebi_q} - 7'd4;

  assign res_last = (res_status_q != ST_OK) || (res_idx_q == KIDX_LAST);
  assign out_fire = out_o.valid && out_o.ready;
  assign buf_free = !res_vld_q || (out_o.ready && res_last);
  assign proc     = in_vld_q && (!in_word_q.last_byte || buf_free);
  assign fin_load = proc && in_word_q.last_byte;
  assign in_i.ready = !in_vld_q || proc;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = (cnt_q < COUNT_MAX) ? cnt_q + 24'd1 : cnt_q;
    decl_d   = decl_q;
    sid_d    = sid_q;
    ebl_d    = ebl_q;
    etype_d  = etype_q;
    ebody_d  = ebody_q;
    ebi_d    = ebi_q;
    rmatch_d = rmatch_q;
    seen_d   = seen_q;
    err_d    = err_q;
    key_we   = 1'b0;
    key_wa   = kofs[KW-1:0];
    used     = (cnt_q >= 24'd3) ? cnt_q - 24'd3 : 24'd0;
    room     = (decl_q >= used) ? decl_q - used : 24'd0;
    unique case (phase_q)
      PH_HEAD: begin
        if (cnt_q == 24'd0) begin
          if (b != HS_TYPE_SERVER_HELLO && err_d == ST_OK) err_d = ST_TYPE;
        end else begin
          decl_d = {decl_q[15:0], b};
        end
        if (cnt_q >= 24'd3) begin
          phase_d = PH_VER;
          ebi_d   = '0;
        end
      end
      PH_VER: begin
        if (b != LEGACY_VER_BYTE && err_d == ST_OK) err_d = ST_VER;
        ebi_d = ebi_inc[5:0];
        if (ebi_inc >= 7'd2) begin
          phase_d = PH_RAND;
          ebi_d   = '0;
        end
      end
      PH_RAND: begin
        if (b != retry_random(ebi_q[4:0])) rmatch_d = 1'b0;
        ebi_d = ebi_inc[5:0];
        if (ebi_inc >= 7'd32) begin
          if (rmatch_d && err_d == ST_OK) err_d = ST_RETRY;
          phase_d = PH_SIDLEN;
          ebi_d   = '0;
        end
      end
      PH_SIDLEN: begin
        sid_d   = b;
        phase_d = (b != 8'd0) ? PH_SID : PH_SUITE;
      end
      PH_SID: begin
        if (sid_q != 8'd0) sid_d = sid_q - 8'd1;
        if (sid_d == 8'd0) phase_d = PH_SUITE;
      end
      PH_SUITE: begin
        if (b != ((ebi_q == 6'd0) ? SUITE_HI : SUITE_LO) && err_d == ST_OK) err_d = ST_SUITE;
        ebi_d = ebi_inc[5:0];
        if (ebi_inc >= 7'd2) begin
          phase_d = PH_COMP;
          ebi_d   = '0;
        end
      end
      PH_COMP: begin
        if (b != 8'd0 && err_d == ST_OK) err_d = ST_COMP;
        phase_d = PH_EXTLEN;
        ebi_d   = '0;
      end
      PH_EXTLEN: begin
        ebl_d = {ebl_q[7:0], b};
        ebi_d = ebi_inc[5:0];
        if (ebi_inc >= 7'd2) begin
          if ({8'd0, ebl_d} > room && err_d == ST_OK) err_d = ST_EXTLEN;
          ebi_d   = '0;
          phase_d = (ebl_d != 16'd0) ? PH_EXTHDR : PH_TAIL;
        end
      end
      PH_EXTHDR: begin
        if (ebi_q == 6'd0 && ebl_q < 16'd4) begin
          if (err_d == ST_OK) err_d = ST_EXTLEN;
          phase_d = PH_TAIL;
        end else begin
          ebl_d = ebl_q - 16'd1;
          if (ebi_q < 6'd2) etype_d = {etype_q[7:0], b};
          else              ebody_d = {ebody_q[7:0], b};
          ebi_d = ebi_inc[5:0];
          if (ebi_inc >= 7'd4) begin
            if (ebody_d > ebl_d) begin
              if (err_d == ST_OK) err_d = ST_EXTLEN;
              phase_d = PH_TAIL;
            end else begin
              if (!((etype_d == EXT_KEY_SHARE && ebody_d == SHARE_BODY_LEN) ||
                    (etype_d == EXT_SUP_VER && ebody_d == SUP_VER_BODY_LEN)))
                etype_d = '0;
              ebi_d = '0;
              if (ebody_d == 16'd0) phase_d = (ebl_d != 16'd0) ? PH_EXTHDR : PH_TAIL;
              else                  phase_d = PH_EXTBODY;
            end
          end
        end
      end
      PH_EXTBODY: begin
        if (etype_q == EXT_KEY_SHARE) begin
          if (ebi_q < 6'd4) begin
            if (err_d == ST_OK &&
                ((ebi_q == 6'd0 && b != 8'h00) || (ebi_q == 6'd1 && b != GROUP_X25519_LO) ||
                 (ebi_q == 6'd2 && b != 8'h00) || (ebi_q == 6'd3 && b != KEY_LEN_BYTE)))
              err_d = ST_SHARE;
          end else if (kofs < 7'(KEY_BYTES)) begin
            key_we = 1'b1;
          end
        end else if (etype_q == EXT_SUP_VER) begin
          if (b != ((ebi_q == 6'd0) ? SUP_VER_HI : SUP_VER_LO) && err_d == ST_OK)
            err_d = ST_SUPVER;
        end
        if (ebi_q < 6'd63) ebi_d = ebi_inc[5:0];
        if (ebody_q != 16'd0) ebody_d = ebody_q - 16'd1;
        if (ebl_q != 16'd0) ebl_d = ebl_q - 16'd1;
        if (ebody_d == 16'd0) begin
          if (etype_q == EXT_KEY_SHARE)    seen_d[0] = 1'b1;
          else if (etype_q == EXT_SUP_VER) seen_d[1] = 1'b1;
          ebi_d   = '0;
          phase_d = (ebl_d != 16'd0) ? PH_EXTHDR : PH_TAIL;
        end
      end
      PH_TAIL: ;
      default: ;
    endcase
  end

  // status precedence at the final byte
  assign decl_plus4 = {1'b0, decl_d} + 25'd4;
  always_comb begin
    if (cnt_d < 24'd4)
      fin_status = ST_LEN;
    else if (err_d == ST_TYPE)
      fin_status = ST_TYPE;
    else if (cnt_d >= COUNT_MAX || decl_plus4 != {1'b0, cnt_d} || decl_d < MIN_BODY_LEN)
      fin_status = ST_LEN;
    else if (err_d == ST_VER || err_d == ST_RETRY)
      fin_status = err_d;
    else if (phase_d != PH_EXTHDR && phase_d != PH_EXTBODY && phase_d != PH_TAIL)
      fin_status = ST_LEN;
    else if (err_d != ST_OK)
      fin_status = err_d;
    else if (phase_d != PH_TAIL)
      fin_status = ST_EXTLEN;
    else if (seen_d != 2'b11)
      fin_status = ST_MISSING;
    else
      fin_status = ST_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) in_word_q <= in_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEAD;
      cnt_q    <= '0;
      decl_q   <= '0;
      sid_q    <= '0;
      ebl_q    <= '0;
      etype_q  <= '0;
      ebody_q  <= '0;
      ebi_q    <= '0;
      rmatch_q <= 1'b1;
      seen_q   <= '0;
      err_q    <= ST_OK;
    end else if (proc) begin
      if (in_word_q.last_byte) begin
        phase_q  <= PH_HEAD;
        cnt_q    <= '0;
        decl_q   <= '0;
        sid_q    <= '0;
        ebl_q    <= '0;
        etype_q  <= '0;
        ebody_q  <= '0;
        ebi_q    <= '0;
        rmatch_q <= 1'b1;
        seen_q   <= '0;
        err_q    <= ST_OK;
      end else begin
        phase_q  <= phase_d;
        cnt_q    <= cnt_d;
        decl_q   <= decl_d;
        sid_q    <= sid_d;
        ebl_q    <= ebl_d;
        etype_q  <= etype_d;
        ebody_q  <= ebody_d;
        ebi_q    <= ebi_d;
        rmatch_q <= rmatch_d;
        seen_q   <= seen_d;
        err_q    <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && key_we) key_q[key_wa] <= b;
  end

  // output buffer snapshot includes a key byte written by the final byte
  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      res_status_q <= fin_status;
      for (int i = 0; i < KEY_BYTES; i++) begin
        res_key_q[i] <= (key_we && key_wa == KW'(i)) ? b : key_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
      res_idx_q <= '0;
    end else if (fin_load) begin
      res_vld_q <= 1'b1;
      res_idx_q <= '0;
    end else if (out_fire) begin
      if (res_last) begin
        res_vld_q <= 1'b0;
      end else begin
        res_idx_q <= res_idx_q + KW'(1);
      end
    end
  end

  assign out_o.valid         = res_vld_q;
  assign out_o.data.status   = res_status_q;
  assign out_o.data.key_byte = (res_status_q == ST_OK) ? res_key_q[res_idx_q] : 8'd0;
  assign out_o.data.run_end  = res_last;

  // a stalled input word is always a final byte behind a busy buffer
  a_stall_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !in_i.ready) |-> (in_word_q.last_byte && res_vld_q))
    else $error("input stalled on a non-final byte");

  // error runs are one word long
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_idx_q != '0) |-> (res_status_q == ST_OK))
    else $error("error status past the first word of a run");

  a_err_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.status != ST_OK) |->
      (out_o.data.key_byte == 8'd0 && out_o.data.run_end))
    else $error("error word carries key data or no run end");

  // a run is only replaced once its last word is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load |-> (!res_vld_q || (out_fire && res_last)))
    else $error("result buffer overwritten mid-run");

endmodule

// ===== bench/tb_top.sv =====
// Testbench for server_hello_validator: directed and random ServerHello messages.
// A scoreboard class predicts the status/key words; needs shv_pkg, shv_stream_if and the RTL.
`timescale 1ns / 100ps

module tb_top;
  import shv_pkg::*;

  localparam logic [255:0] RETRY_MAGIC =
    256'hCF21AD74C3FD7749_206D5D601DF2EEF7_07D042A9378ECD1F_3829B3730B378E3E;

  typedef enum logic [3:0] {
    P_HEAD, P_VER, P_RAND, P_SIDLEN, P_SID, P_SUITE, P_COMP,
    P_EXTLEN, P_EXTHDR, P_EXTBODY, P_TAIL
  } phase_e;

  function automatic logic [7:0] hrr_byte(int i);
    return RETRY_MAGIC[255 - 8 * i -: 8];
  endfunction

  class hello_scoreboard;
    logic [23:0]  count;
    logic [23:0]  decl;
    phase_e       phase;
    logic [7:0]   sid_left;
    logic [15:0]  blk_left;
    logic [15:0]  ext_kind;
    logic [15:0]  body_left;
    int unsigned  pos;
    bit           retry_hit;
    logic [1:0]   seen;
    status_e      err;
    logic [7:0]   key [KEY_BYTES_DEF];
    out_word_t    expected [$];
    int           mismatches;
    int           checked;
    int           good_runs;

    function new();
      foreach (key[i]) key[i] = 8'h00;
      restart();
    endfunction

    function void restart();
      count = '0;
      decl = '0;
      phase = P_HEAD;
      sid_left = '0;
      blk_left = '0;
      ext_kind = '0;
      body_left = '0;
      pos = 0;
      retry_hit = 1'b1;
      seen = '0;
      err = ST_OK;
    endfunction

    function void flag(status_e code);
      if (err == ST_OK) err = code;
    endfunction

    function void next_ext();
      pos = 0;
      phase = (blk_left != 0) ? P_EXTHDR : P_TAIL;
    endfunction

    function void take_byte(logic [7:0] b);
      logic [23:0] idx;
      logic [23:0] used;
      logic [23:0] room;
      logic [7:0]  want;
      idx = count;
      if (count != COUNT_MAX) count++;
      case (phase)
        P_HEAD: begin
          if (idx == 0) begin
            if (b != HS_TYPE_SERVER_HELLO) flag(ST_TYPE);
          end else begin
            decl = {decl[15:0], b};
          end
          if (idx >= 3) begin
            phase = P_VER;
            pos = 0;
          end
        end
        P_VER: begin
          if (b != LEGACY_VER_BYTE) flag(ST_VER);
          pos++;
          if (pos >= 2) begin
            phase = P_RAND;
            pos = 0;
          end
        end
        P_RAND: begin
          if (b != hrr_byte(pos)) retry_hit = 1'b0;
          pos++;
          if (pos >= 32) begin
            if (retry_hit) flag(ST_RETRY);
            phase = P_SIDLEN;
            pos = 0;
          end
        end
        P_SIDLEN: begin
          sid_left = b;
          phase = (b != 0) ? P_SID : P_SUITE;
        end
        P_SID: begin
          if (sid_left > 0) sid_left--;
          if (sid_left == 0) phase = P_SUITE;
        end
        P_SUITE: begin
          want = (pos == 0) ? SUITE_HI : SUITE_LO;
          if (b != want) flag(ST_SUITE);
          pos++;
          if (pos >= 2) begin
            phase = P_COMP;
            pos = 0;
          end
        end
        P_COMP: begin
          if (b != 8'h00) flag(ST_COMP);
          phase = P_EXTLEN;
          pos = 0;
        end
        P_EXTLEN: begin
          blk_left = {blk_left[7:0], b};
          pos++;
          if (pos >= 2) begin
            used = (idx >= 3) ? idx - 24'd3 : 24'd0;
            room = (decl >= used) ? decl - used : 24'd0;
            if ({8'd0, blk_left} > room) flag(ST_EXTLEN);
            next_ext();
          end
        end
        P_EXTHDR: begin
          if (pos == 0 && blk_left < 16'd4) begin
            flag(ST_EXTLEN);
            phase = P_TAIL;
          end else begin
            blk_left--;
            if (pos < 2) ext_kind = {ext_kind[7:0], b};
            else body_left = {body_left[7:0], b};
            pos++;
            if (pos >= 4) begin
              if (body_left > blk_left) begin
                flag(ST_EXTLEN);
                phase = P_TAIL;
              end else begin
                if (!((ext_kind == EXT_KEY_SHARE && body_left == 16'(KEY_BYTES_DEF + 4)) ||
                      (ext_kind == EXT_SUP_VER && body_left == SUP_VER_BODY_LEN)))
                  ext_kind = '0;
                pos = 0;
                if (body_left == 0) next_ext();
                else phase = P_EXTBODY;
              end
            end
          end
        end
        P_EXTBODY: begin
          if (ext_kind == EXT_KEY_SHARE) begin
            if (pos < 4) begin
              case (pos)
                0: want = 8'h00;
                1: want = GROUP_X25519_LO;
                2: want = 8'h00;
                default: want = 8'(KEY_BYTES_DEF);
              endcase
              if (b != want) flag(ST_SHARE);
            end else if (pos - 4 < KEY_BYTES_DEF) begin
              key[pos - 4] = b;
            end
          end else if (ext_kind == EXT_SUP_VER) begin
            want = (pos == 0) ? SUP_VER_HI : SUP_VER_LO;
            if (b != want) flag(ST_SUPVER);
          end
          if (pos < 63) pos++;
          if (body_left > 0) body_left--;
          if (blk_left > 0) blk_left--;
          if (body_left == 0) begin
            if (ext_kind == EXT_KEY_SHARE) seen[0] = 1'b1;
            else if (ext_kind == EXT_SUP_VER) seen[1] = 1'b1;
            next_ext();
          end
        end
        default: ;
      endcase
    endfunction

    function status_e verdict();
      if (count < 24'd4) return ST_LEN;
      if (err == ST_TYPE) return ST_TYPE;
      if (count == COUNT_MAX || ({8'd0, decl} + 32'd4) != {8'd0, count} ||
          decl < MIN_BODY_LEN)
        return ST_LEN;
      if (err == ST_VER || err == ST_RETRY) return err;
      if (phase < P_EXTHDR) return ST_LEN;
      if (err != ST_OK) return err;
      if (phase != P_TAIL) return ST_EXTLEN;
      if (seen != 2'b11) return ST_MISSING;
      return ST_OK;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      status_e st;
      out_word_t w;
      take_byte(b);
      if (!last) return;
      st = verdict();
      restart();
      if (st != ST_OK) begin
        w.status = st;
        w.key_byte = 8'h00;
        w.run_end = 1'b1;
        expected.push_back(w);
      end else begin
        good_runs++;
        for (int k = 0; k < KEY_BYTES_DEF; k++) begin
          w.status = ST_OK;
          w.key_byte = key[k];
          w.run_end = (k == KEY_BYTES_DEF - 1);
          expected.push_back(w);
        end
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word status=%0d key=%02h end=%0b",
                 $time, got.status, got.key_byte, got.run_end);
        return;
      end
      want = expected.pop_front();
      checked++;
      if (got.status !== want.status) begin
        mismatches++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
      if (got.key_byte !== want.key_byte) begin
        mismatches++;
        $display("%0t: key_byte expected %02h actual %02h",
                 $time, want.key_byte, got.key_byte);
      end
      if (got.run_end !== want.run_end) begin
        mismatches++;
        $display("%0t: run_end expected %0b actual %0b", $time, want.run_end, got.run_end);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  shv_stream_if #(.T(in_word_t))  in_if ();
  shv_stream_if #(.T(out_word_t)) out_if ();

  server_hello_validator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  hello_scoreboard sb = new();

  logic [7:0] msg [$];
  logic [7:0] ext_blk [$];
  int         ext_pos;
  int         msgs_sent;
  int         bytes_sent;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function void add_share(logic [7:0] grp, logic [7:0] klen);
    ext_blk.push_back(8'h00);
    ext_blk.push_back(EXT_KEY_SHARE[7:0]);
    ext_blk.push_back(8'h00);
    ext_blk.push_back(8'(KEY_BYTES_DEF + 4));
    ext_blk.push_back(8'h00);
    ext_blk.push_back(grp);
    ext_blk.push_back(8'h00);
    ext_blk.push_back(klen);
    repeat (KEY_BYTES_DEF) ext_blk.push_back(8'($urandom));
  endfunction

  function void add_supver(logic [7:0] lo);
    ext_blk.push_back(8'h00);
    ext_blk.push_back(EXT_SUP_VER[7:0]);
    ext_blk.push_back(8'h00);
    ext_blk.push_back(SUP_VER_BODY_LEN[7:0]);
    ext_blk.push_back(SUP_VER_HI);
    ext_blk.push_back(lo);
  endfunction

  function void add_other(logic [15:0] kind, logic [15:0] declared, int actual);
    ext_blk.push_back(kind[15:8]);
    ext_blk.push_back(kind[7:0]);
    ext_blk.push_back(declared[15:8]);
    ext_blk.push_back(declared[7:0]);
    repeat (actual) ext_blk.push_back(8'($urandom));
  endfunction

  function void fix_len();
    logic [23:0] body;
    body = 24'(msg.size() - 4);
    msg[1] = body[23:16];
    msg[2] = body[15:8];
    msg[3] = body[7:0];
  endfunction

  function void assemble(int sid_len, int tail, bit retry);
    logic [15:0] elen;
    msg.delete();
    msg.push_back(HS_TYPE_SERVER_HELLO);
    repeat (3) msg.push_back(8'h00);
    msg.push_back(LEGACY_VER_BYTE);
    msg.push_back(LEGACY_VER_BYTE);
    for (int i = 0; i < 32; i++) msg.push_back(retry ? hrr_byte(i) : 8'($urandom));
    msg.push_back(8'(sid_len));
    repeat (sid_len) msg.push_back(8'($urandom));
    msg.push_back(SUITE_HI);
    msg.push_back(SUITE_LO);
    msg.push_back(8'h00);
    elen = 16'(ext_blk.size());
    msg.push_back(elen[15:8]);
    msg.push_back(elen[7:0]);
    ext_pos = msg.size();
    foreach (ext_blk[j]) msg.push_back(ext_blk[j]);
    repeat (tail) msg.push_back(8'($urandom));
    fix_len();
  endfunction

  task automatic send_byte(logic [7:0] b, logic last, bit quiet);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= {b, last};
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_msg();
    bit quiet;
    quiet = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1, quiet);
    msgs_sent++;
  endtask

  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // result sink with random stalls and stall-free stretches
  initial begin
    int stall;
    int quiet_left;
    quiet_left = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (quiet_left > 0) begin
        stall = 0;
        quiet_left--;
      end else if ($urandom_range(0, 15) == 0) begin
        quiet_left = $urandom_range(20, 60);
        stall = 0;
      end else begin
        stall = $urandom_range(0, 6);
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (out_if.valid !== 1'b1) @(posedge clk_i);
      sb.check_word(out_if.data);
    end
  end

  initial begin
    int n;
    int ps;
    int pv;
    int k;
    int sid;
    int tail;
    bit retry;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    msgs_sent = 0;
    bytes_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // good message with session id, unknown and skipped extensions,
    // a key_share overwrite and bytes after the extension block
    ext_blk.delete();
    add_other(16'hFFFF, 16'd0, 0);
    add_share(GROUP_X25519_LO, 8'(KEY_BYTES_DEF));
    add_other(EXT_KEY_SHARE, 16'd5, 5);
    add_supver(SUP_VER_LO);
    add_share(GROUP_X25519_LO, 8'(KEY_BYTES_DEF));
    assemble(2, 3, 0);
    send_msg();
    // bad type in a four byte message
    msg.delete();
    msg.push_back(8'hFF);
    repeat (3) msg.push_back(8'h00);
    send_msg();
    // too short: one byte
    msg.delete();
    msg.push_back(HS_TYPE_SERVER_HELLO);
    send_msg();
    // legacy version
    ext_blk.delete();
    assemble(0, 0, 0);
    msg[5] = 8'h02;
    send_msg();
    // retry random
    ext_blk.delete();
    assemble(0, 0, 1);
    send_msg();
    // missing key_share
    ext_blk.delete();
    add_supver(SUP_VER_LO);
    assemble(0, 0, 0);
    send_msg();
    // wrong group
    ext_blk.delete();
    add_share(8'h1E, 8'(KEY_BYTES_DEF));
    assemble(0, 0, 0);
    send_msg();

    while (bytes_sent < 420) begin
      if ($urandom_range(0, 9) < 2) begin
        msg.delete();
        n = $urandom_range(1, 60);
        repeat (n) msg.push_back(8'($urandom));
        if ($urandom_range(0, 1)) msg[0] = HS_TYPE_SERVER_HELLO;
        if (n >= 4 && $urandom_range(0, 1)) fix_len();
      end else begin
        ext_blk.delete();
        n = $urandom_range(2, 4);
        ps = $urandom_range(0, n - 1);
        pv = (ps + $urandom_range(1, n - 1)) % n;
        for (int i = 0; i < n; i++) begin
          if (i == ps) add_share(GROUP_X25519_LO, 8'(KEY_BYTES_DEF));
          else if (i == pv) add_supver(SUP_VER_LO);
          else begin
            case ($urandom_range(0, 3))
              0: begin
                k = $urandom_range(0, 8);
                add_other(16'($urandom), 16'(k), k);
              end
              1: add_share(GROUP_X25519_LO, 8'(KEY_BYTES_DEF));
              2: add_supver(SUP_VER_LO);
              default: begin
                k = $urandom_range(0, 40);
                add_other(EXT_KEY_SHARE, 16'(k), k);
              end
            endcase
          end
        end
        sid = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : 0;
        if ($urandom_range(0, 19) == 0) sid = $urandom_range(33, 255);
        tail = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
        retry = ($urandom_range(0, 19) == 0);
        assemble(sid, tail, retry);
        if ($urandom_range(0, 9) < 4) begin
          case ($urandom_range(0, 5))
            0: msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
            1: begin
              k = $urandom_range(0, msg.size() - 1);
              msg[k] = msg[k] ^ (8'h01 << $urandom_range(0, 7));
            end
            2: begin
              k = $urandom_range(1, msg.size() - 1);
              while (msg.size() > k) void'(msg.pop_back());
              if (k >= 4 && $urandom_range(0, 1)) fix_len();
            end
            3: begin
              repeat ($urandom_range(1, 5)) msg.push_back(8'($urandom));
              if ($urandom_range(0, 1)) fix_len();
            end
            4: msg[$urandom_range(ext_pos, msg.size() - 1)] = 8'($urandom);
            default: repeat (2) msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
          endcase
        end
      end
      send_msg();
    end

    in_if.valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("tb_top: %0d messages (%0d bytes) sent, %0d passed validation",
             msgs_sent, bytes_sent, sb.good_runs);
    $display("tb_top: %0d result words checked, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/shv_pkg.sv
rtl/core/shv_stream_if.sv
rtl/core/server_hello_validator.sv
bench/tb_top.sv
